[rtl/dcsc_pkg.sv]
// ----------------------------------------------------------------------------
// dcsc_pkg
// Shared types and constants for the disk controller status and command unit.
// ----------------------------------------------------------------------------
package dcsc_pkg;

  // Number of drives actually built (1 to 8).
  localparam int DRIVES     = 8;
  // Drive storage is always sized for the full 3-bit drive number.
  localparam int MAX_DRIVES = 8;

  localparam int WORD_W  = 36;
  localparam int OP_W    = 3;
  localparam int LVL_W   = 3;
  localparam int SEL_W   = 3;
  localparam int UNIT_W  = 4;
  localparam int CMD_W   = 3;
  localparam int DELAY_W = 10;
  localparam int MASK_W  = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  // Bus operations.
  localparam logic [OP_W-1:0] OP_STATUS_RD  = 3'd0;
  localparam logic [OP_W-1:0] OP_CONTROL_WR = 3'd1;
  localparam logic [OP_W-1:0] OP_DATA_RD    = 3'd2;
  localparam logic [OP_W-1:0] OP_COMMAND_WR = 3'd3;
  localparam logic [OP_W-1:0] OP_TICK       = 3'd4;

  // Drive commands.
  localparam logic [CMD_W-1:0] CMD_NOP   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_RECAL = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SEEK  = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_WRITE = 3'd6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_DELAY   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ONLINE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROTECT = 2'd2;

  localparam logic [DELAY_W-1:0] DELAY_RESET = 10'd100;

  // Field positions in the bus word.
  localparam int PRIO_LSB = 0;
  localparam int UNIT_LSB = 9;
  localparam int CMD_LSB  = 13;

  // Status word bit positions.
  localparam int ST_DONE_BIT    = 8;
  localparam int ST_UNIT_LSB    = 9;
  localparam int ST_DBUSY_BIT   = 13;
  localparam int ST_CBUSY_BIT   = 15;
  localparam int ST_RO_BIT      = 20;
  localparam int ST_SEEK_BIT    = 22;
  localparam int ST_OFFLINE_BIT = 23;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [WORD_W-1:0] write_data;
  } item_t;

  typedef struct packed {
    logic [DELAY_W-1:0] completion_delay;
    logic [MASK_W-1:0]  drive_online_mask;
    logic [MASK_W-1:0]  drive_protect_mask;
  } cfg_regs_t;

endpackage

[rtl/dcsc_if.sv]
// ----------------------------------------------------------------------------
// dcsc_if
// Valid/ready channel interfaces for items, results and configuration writes.
// ----------------------------------------------------------------------------
interface dcsc_in_if;
  logic                          valid;
  logic                          ready;
  logic [dcsc_pkg::OP_W-1:0]     operation;
  logic [dcsc_pkg::WORD_W-1:0]   write_data;

  modport source (output valid, output operation, output write_data, input ready);
  modport sink   (input valid, input operation, input write_data, output ready);
endinterface

interface dcsc_out_if;
  logic                          valid;
  logic                          ready;
  logic [dcsc_pkg::WORD_W-1:0]   read_data;
  logic                          interrupt_request;
  logic [dcsc_pkg::LVL_W-1:0]    interrupt_level;
  logic                          bad_unit;

  modport source (output valid, output read_data, output interrupt_request,
                  output interrupt_level, output bad_unit, input ready);
  modport sink   (input valid, input read_data, input interrupt_request,
                  input interrupt_level, input bad_unit, output ready);
endinterface

interface dcsc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [dcsc_pkg::CFG_IDX_W-1:0]    index;
  logic [dcsc_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/dcsc_cfg.sv]
// ----------------------------------------------------------------------------
// dcsc_cfg
// Configuration registers: completion delay and the drive online/protect masks.
// ----------------------------------------------------------------------------
module dcsc_cfg (
  input  logic                clk,
  input  logic                rst_n,
  dcsc_cfg_if.sink            cfg_ch,
  output dcsc_pkg::cfg_regs_t regs
);

  dcsc_pkg::cfg_regs_t regs_r;

  assign cfg_ch.ready = 1'b1;
  assign regs         = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.completion_delay   <= dcsc_pkg::DELAY_RESET;
      regs_r.drive_online_mask  <= '0;
      regs_r.drive_protect_mask <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        dcsc_pkg::CFG_DELAY: begin
          regs_r.completion_delay <= cfg_ch.data[dcsc_pkg::DELAY_W-1:0];
        end
        dcsc_pkg::CFG_ONLINE: begin
          regs_r.drive_online_mask <= cfg_ch.data[dcsc_pkg::MASK_W-1:0];
        end
        dcsc_pkg::CFG_PROTECT: begin
          regs_r.drive_protect_mask <= cfg_ch.data[dcsc_pkg::MASK_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[rtl/dcsc_in_reg.sv]
// ----------------------------------------------------------------------------
// dcsc_in_reg
// Input register stage that captures one bus item per cycle while it is empty or the core takes its item.
// ----------------------------------------------------------------------------
module dcsc_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  dcsc_in_if.sink         in_ch,
  output logic            stage_valid,
  output dcsc_pkg::item_t stage_item,
  input  logic            stage_take
);

  logic            valid_r;
  dcsc_pkg::item_t item_r;

  assign in_ch.ready  = !valid_r || stage_take;
  assign stage_valid  = valid_r;
  assign stage_item   = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.operation  <= in_ch.operation;
      item_r.write_data <= in_ch.write_data;
    end
  end

endmodule

[rtl/dcsc_core.sv]
// ----------------------------------------------------------------------------
// dcsc_core
// Controller state, command start, per-drive countdowns and the result register.
// ----------------------------------------------------------------------------
module dcsc_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                stage_valid,
  input  dcsc_pkg::item_t     stage_item,
  output logic                stage_take,
  input  dcsc_pkg::cfg_regs_t regs,
  dcsc_out_if.source          out_ch
);

  localparam int ND = dcsc_pkg::MAX_DRIVES;

  // Controller state.
  logic [dcsc_pkg::SEL_W-1:0]   sel_r,  sel_nxt;
  logic [dcsc_pkg::LVL_W-1:0]   prio_r, prio_nxt;
  logic [ND-1:0]                attn_r, attn_nxt;
  logic                         done_r, done_nxt;
  logic                         cbusy_r, cbusy_nxt;
  logic                         seek_r, seek_nxt;
  logic                         irq_r, irq_nxt;
  logic [dcsc_pkg::CMD_W-1:0]   pend_r   [ND];
  logic [dcsc_pkg::CMD_W-1:0]   pend_nxt [ND];
  logic [dcsc_pkg::DELAY_W-1:0] cnt_r    [ND];
  logic [dcsc_pkg::DELAY_W-1:0] cnt_nxt  [ND];

  // Result register.
  logic                         out_valid_r;
  logic [dcsc_pkg::WORD_W-1:0]  rd_r, rd_nxt;
  logic                         bad_r, bad_nxt;

  logic                         fire;
  logic [dcsc_pkg::WORD_W-1:0]  w;
  logic [dcsc_pkg::UNIT_W-1:0]  unit;
  logic                         unit_bad;
  logic [dcsc_pkg::SEL_W-1:0]   sel_new;
  logic [dcsc_pkg::CMD_W-1:0]   cmd;
  logic                         cmd_seek;
  logic                         cmd_xfer;
  logic [dcsc_pkg::DELAY_W-1:0] start_cnt;
  logic [ND-1:0]                fin;
  logic [ND-1:0]                fin_seek;
  logic [ND-1:0]                fin_xfer;

  assign stage_take = !out_valid_r || out_ch.ready;
  assign fire       = stage_valid && stage_take;

  assign w         = stage_item.write_data;
  assign unit      = w[dcsc_pkg::UNIT_LSB +: dcsc_pkg::UNIT_W];
  assign unit_bad  = unit > dcsc_pkg::UNIT_W'(dcsc_pkg::DRIVES);
  // A unit field of zero keeps the selection; a missing drive leaves it too.
  assign sel_new   = (unit == '0 || unit_bad) ? sel_r :
                     dcsc_pkg::SEL_W'(unit - dcsc_pkg::UNIT_W'(1));
  assign cmd       = w[dcsc_pkg::CMD_LSB +: dcsc_pkg::CMD_W];
  assign cmd_seek  = (cmd == dcsc_pkg::CMD_RECAL) || (cmd == dcsc_pkg::CMD_SEEK);
  assign cmd_xfer  = (cmd == dcsc_pkg::CMD_READ) || (cmd == dcsc_pkg::CMD_WRITE);
  assign start_cnt = (regs.completion_delay == '0) ? dcsc_pkg::DELAY_W'(1)
                                                   : regs.completion_delay;

  // A drive completes on a tick when its countdown is at one.
  always_comb begin
    for (int i = 0; i < ND; i++) begin
      fin[i]      = (i < dcsc_pkg::DRIVES) && (cnt_r[i] == dcsc_pkg::DELAY_W'(1));
      fin_seek[i] = fin[i] && ((pend_r[i] == dcsc_pkg::CMD_RECAL) ||
                               (pend_r[i] == dcsc_pkg::CMD_SEEK));
      fin_xfer[i] = fin[i] && ((pend_r[i] == dcsc_pkg::CMD_READ) ||
                               (pend_r[i] == dcsc_pkg::CMD_WRITE));
    end
  end

  always_comb begin
    sel_nxt   = sel_r;
    prio_nxt  = prio_r;
    attn_nxt  = attn_r;
    done_nxt  = done_r;
    cbusy_nxt = cbusy_r;
    seek_nxt  = seek_r;
    irq_nxt   = irq_r;
    pend_nxt  = pend_r;
    cnt_nxt   = cnt_r;
    rd_nxt    = '0;
    bad_nxt   = 1'b0;

    case (stage_item.operation)
      dcsc_pkg::OP_STATUS_RD: begin
        rd_nxt[ND-1:0]                     = attn_r;
        rd_nxt[dcsc_pkg::ST_DONE_BIT]      = done_r;
        rd_nxt[dcsc_pkg::ST_UNIT_LSB +: dcsc_pkg::UNIT_W] =
          dcsc_pkg::UNIT_W'(sel_r) + dcsc_pkg::UNIT_W'(1);
        rd_nxt[dcsc_pkg::ST_DBUSY_BIT]     = cnt_r[sel_r] != '0;
        rd_nxt[dcsc_pkg::ST_CBUSY_BIT]     = cbusy_r;
        rd_nxt[dcsc_pkg::ST_RO_BIT]        = regs.drive_protect_mask[sel_r];
        rd_nxt[dcsc_pkg::ST_SEEK_BIT]      = seek_r;
        rd_nxt[dcsc_pkg::ST_OFFLINE_BIT]   = !regs.drive_online_mask[sel_r];
      end
      dcsc_pkg::OP_CONTROL_WR: begin
        done_nxt = 1'b0;
        prio_nxt = w[dcsc_pkg::PRIO_LSB +: dcsc_pkg::LVL_W];
        sel_nxt  = sel_new;
        bad_nxt  = unit_bad;
        irq_nxt  = (prio_nxt != '0) && (attn_r != '0) && !cbusy_r;
      end
      dcsc_pkg::OP_COMMAND_WR: begin
        sel_nxt           = sel_new;
        bad_nxt           = unit_bad;
        done_nxt          = 1'b0;
        attn_nxt[sel_new] = 1'b0;
        pend_nxt[sel_new] = cmd;
        if (cmd_seek || cmd_xfer) begin
          cbusy_nxt = 1'b1;
          // A busy drive keeps its running countdown.
          if (cnt_r[sel_new] == '0) begin
            cnt_nxt[sel_new] = start_cnt;
          end
        end
        if (cmd_seek) begin
          seek_nxt = 1'b1;
        end
        irq_nxt = (prio_r != '0) && (attn_nxt != '0) && !cbusy_nxt;
      end
      dcsc_pkg::OP_TICK: begin
        for (int i = 0; i < ND; i++) begin
          if (i < dcsc_pkg::DRIVES && cnt_r[i] != '0) begin
            cnt_nxt[i] = cnt_r[i] - dcsc_pkg::DELAY_W'(1);
          end
        end
        if (fin != '0) begin
          cbusy_nxt = 1'b0;
          attn_nxt  = attn_r | fin_seek;
          if (fin_seek != '0) begin
            seek_nxt = 1'b0;
          end
          if (fin_xfer != '0) begin
            done_nxt = 1'b1;
          end
          irq_nxt = (prio_r != '0) && ((attn_nxt != '0) || done_nxt);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r       <= '0;
      prio_r      <= '0;
      attn_r      <= '0;
      done_r      <= 1'b0;
      cbusy_r     <= 1'b0;
      seek_r      <= 1'b0;
      irq_r       <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < ND; i++) begin
        pend_r[i] <= dcsc_pkg::CMD_NOP;
        cnt_r[i]  <= '0;
      end
    end else begin
      if (stage_take) begin
        out_valid_r <= stage_valid;
      end
      if (fire) begin
        sel_r   <= sel_nxt;
        prio_r  <= prio_nxt;
        attn_r  <= attn_nxt;
        done_r  <= done_nxt;
        cbusy_r <= cbusy_nxt;
        seek_r  <= seek_nxt;
        irq_r   <= irq_nxt;
        pend_r  <= pend_nxt;
        cnt_r   <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rd_r  <= rd_nxt;
      bad_r <= bad_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.read_data         = rd_r;
  assign out_ch.bad_unit          = bad_r;
  // Level and interrupt only change when the next item is processed, which
  // happens only as this result is taken.
  assign out_ch.interrupt_request = irq_r;
  assign out_ch.interrupt_level   = prio_r;

endmodule

[rtl/disk_controller_status_and_command_unit.sv]
// ----------------------------------------------------------------------------
// disk_controller_status_and_command_unit
// Register face of a multi-drive disk controller with per-drive countdowns.
// ----------------------------------------------------------------------------
// Each item is a status read, control write, data read, command write or
// tick, and produces exactly one result. An item passes through an input
// register, is processed against the controller state combinationally, and
// lands in a result register, so one item is accepted every clock cycle when
// the result side is ready. The throughput is set by the combinational state
// update: all drive countdowns step in parallel on a tick. Configuration
// writes are taken on any cycle and should only be issued while no item is
// in flight.
module disk_controller_status_and_command_unit (
  input  logic       clk,
  input  logic       rst_n,
  dcsc_in_if.sink    in_ch,
  dcsc_out_if.source out_ch,
  dcsc_cfg_if.sink   cfg_ch
);

  dcsc_pkg::cfg_regs_t regs;
  logic                stage_valid;
  dcsc_pkg::item_t     stage_item;
  logic                stage_take;

  dcsc_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .regs   (regs)
  );

  dcsc_in_reg u_in_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .stage_valid (stage_valid),
    .stage_item  (stage_item),
    .stage_take  (stage_take)
  );

  dcsc_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .stage_valid (stage_valid),
    .stage_item  (stage_item),
    .stage_take  (stage_take),
    .regs        (regs),
    .out_ch      (out_ch)
  );

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking test of the disk controller status and command unit. Bus
// accesses and ticks go in over the item channel. Each result is checked
// against a cycle-free model of the controller registers kept in this file.
// Directed items cover the field extremes and corner cases, and random
// traffic covers several register settings and handshake idle patterns.
// ----------------------------------------------------------------------------
module testbench;
  import dcsc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 57;

  // Operation codes with no function, and command codes with no action.
  localparam logic [OP_W-1:0]  OP_SPARE_LO = 3'd5;
  localparam logic [OP_W-1:0]  OP_SPARE_HI = 3'd7;
  localparam logic [CMD_W-1:0] CMD_SPARE_1 = 3'd1;
  localparam logic [CMD_W-1:0] CMD_SPARE_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [WORD_W-1:0] read_data;
    logic              interrupt_request;
    logic [LVL_W-1:0]  interrupt_level;
    logic              bad_unit;
  } status_result_t;

  logic clk = 1'b0;
  logic rst_n;

  dcsc_in_if  in_ch ();
  dcsc_out_if out_ch ();
  dcsc_cfg_if cfg_ch ();

  disk_controller_status_and_command_unit DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #6 clk = ~clk;

  // Controller registers as the model sees them.
  logic [DELAY_W-1:0] cfg_delay;
  logic [MASK_W-1:0]  online_mask;
  logic [MASK_W-1:0]  protect_mask;

  logic [SEL_W-1:0]   sel_drive;
  logic [LVL_W-1:0]   prio_chan;
  logic [MASK_W-1:0]  attn;
  logic               done_f;
  logic               ctrl_busy;
  logic               seek_inc;
  logic               irq_line;
  logic [CMD_W-1:0]   pend_cmd [MAX_DRIVES];
  logic [DELAY_W-1:0] drv_countdown [MAX_DRIVES];

  status_result_t expected_status [$];

  int send_idle_pct;
  int recv_idle_pct;
  int items_sent;
  int results_checked;
  int mismatch_count;
  int completions;
  int bad_units;
  int settings_used;
  int cycle_count;

  function automatic void update_irq();
    irq_line = (prio_chan != '0) && ((attn != '0) || done_f) && !ctrl_busy;
  endfunction

  // Returns 1 when the unit field names a drive that is not built.
  function automatic logic apply_unit(input logic [WORD_W-1:0] w);
    logic [UNIT_W-1:0] u;
    u = w[UNIT_LSB +: UNIT_W];
    if (u == '0) return 1'b0;
    if (u > UNIT_W'(DRIVES)) return 1'b1;
    sel_drive = SEL_W'(u - UNIT_W'(1));
    return 1'b0;
  endfunction

  function automatic status_result_t predict_bus_access(input logic [OP_W-1:0] op,
                                                        input logic [WORD_W-1:0] w);
    status_result_t res;
    logic [SEL_W-1:0] d;
    logic [CMD_W-1:0] code;
    logic starts;
    logic any_done;
    res = '0;
    d = sel_drive;
    starts = 1'b0;
    any_done = 1'b0;
    case (op)
      OP_STATUS_RD: begin
        res.read_data[MASK_W-1:0] = attn;
        res.read_data[ST_DONE_BIT] = done_f;
        res.read_data[ST_UNIT_LSB +: UNIT_W] = {1'b0, d} + UNIT_W'(1);
        res.read_data[ST_DBUSY_BIT] = (drv_countdown[d] != '0);
        res.read_data[ST_CBUSY_BIT] = ctrl_busy;
        res.read_data[ST_RO_BIT] = protect_mask[d];
        res.read_data[ST_SEEK_BIT] = seek_inc;
        res.read_data[ST_OFFLINE_BIT] = !online_mask[d];
      end
      OP_CONTROL_WR: begin
        done_f = 1'b0;
        prio_chan = w[PRIO_LSB +: LVL_W];
        res.bad_unit = apply_unit(w);
        update_irq();
      end
      OP_COMMAND_WR: begin
        // A bad unit leaves the previous selection as the target.
        res.bad_unit = apply_unit(w);
        d = sel_drive;
        done_f = 1'b0;
        attn[d] = 1'b0;
        code = w[CMD_LSB +: CMD_W];
        pend_cmd[d] = code;
        if (code == CMD_RECAL || code == CMD_SEEK) begin
          ctrl_busy = 1'b1;
          seek_inc = 1'b1;
          starts = 1'b1;
        end else if (code == CMD_READ || code == CMD_WRITE) begin
          ctrl_busy = 1'b1;
          starts = 1'b1;
        end
        // A drive that is already counting keeps its countdown.
        if (starts && drv_countdown[d] == '0)
          drv_countdown[d] = (cfg_delay == '0) ? DELAY_W'(1) : cfg_delay;
        update_irq();
      end
      OP_TICK: begin
        for (int i = 0; i < DRIVES; i++) begin
          if (drv_countdown[i] != '0) begin
            drv_countdown[i] = drv_countdown[i] - DELAY_W'(1);
            if (drv_countdown[i] == '0) begin
              ctrl_busy = 1'b0;
              case (pend_cmd[i])
                CMD_RECAL, CMD_SEEK: begin
                  attn[i] = 1'b1;
                  seek_inc = 1'b0;
                end
                CMD_READ, CMD_WRITE: done_f = 1'b1;
                default: ;
              endcase
              any_done = 1'b1;
              completions++;
            end
          end
        end
        if (any_done) update_irq();
      end
      default: ;
    endcase
    res.interrupt_request = irq_line;
    res.interrupt_level = prio_chan;
    if (res.bad_unit) bad_units++;
    return res;
  endfunction

  function automatic logic [WORD_W-1:0] bus_word(input logic [LVL_W-1:0] lvl,
                                                 input logic [UNIT_W-1:0] unit,
                                                 input logic [CMD_W-1:0] code);
    logic [WORD_W-1:0] w;
    w[31:0] = $urandom;
    w[WORD_W-1:32] = 4'($urandom_range(15));
    w[PRIO_LSB +: LVL_W] = lvl;
    w[UNIT_LSB +: UNIT_W] = unit;
    w[CMD_LSB +: CMD_W] = code;
    return w;
  endfunction

  task automatic send_item(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.write_data <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_status.push_back(predict_bus_access(op, w));
    items_sent++;
  endtask

  // Holds the item channel until every outstanding result has come back.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_status.size() != 0);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      CFG_DELAY:   cfg_delay = val[DELAY_W-1:0];
      CFG_ONLINE:  online_mask = val[MASK_W-1:0];
      CFG_PROTECT: protect_mask = val[MASK_W-1:0];
      default: ;
    endcase
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_registers(input logic [DELAY_W-1:0] delay,
                               input logic [MASK_W-1:0] online,
                               input logic [MASK_W-1:0] protect);
    drain_results();
    write_register(CFG_DELAY, delay);
    write_register(CFG_ONLINE, {2'($urandom_range(3)), online});
    write_register(CFG_PROTECT, {2'($urandom_range(3)), protect});
    settings_used++;
  endtask

  task automatic test_reset_defaults();
    send_item(OP_STATUS_RD, bus_word(3'd7, 4'd15, CMD_WRITE));
    send_item(OP_DATA_RD, bus_word(3'd7, 4'd8, CMD_SEEK));
    send_item(OP_SPARE_HI, bus_word(3'd5, 4'd3, CMD_READ));
    send_item(OP_TICK, bus_word(3'd0, 4'd0, CMD_NOP));
  endtask

  task automatic test_control_and_units();
    set_registers(DELAY_RESET, 8'hFF, 8'hA5);
    send_item(OP_CONTROL_WR, bus_word(3'd7, 4'd8, CMD_NOP));
    send_item(OP_STATUS_RD, '0);
    send_item(OP_CONTROL_WR, bus_word(3'd0, 4'd9, CMD_SEEK));
    send_item(OP_CONTROL_WR, bus_word(3'd1, 4'd15, CMD_WRITE));
    send_item(OP_CONTROL_WR, bus_word(3'd5, 4'd0, CMD_READ));
    send_item(OP_SPARE_LO, {WORD_W{1'b1}});
    send_item(OP_STATUS_RD, {WORD_W{1'b1}});
  endtask

  task automatic test_command_codes();
    // A zero delay behaves like a delay of one tick.
    set_registers('0, 8'h5A, 8'h0F);
    send_item(OP_COMMAND_WR, bus_word(3'd2, 4'd1, CMD_RECAL));
    send_item(OP_COMMAND_WR, bus_word(3'd6, 4'd2, CMD_SEEK));
    send_item(OP_COMMAND_WR, bus_word(3'd1, 4'd3, CMD_READ));
    send_item(OP_COMMAND_WR, bus_word(3'd4, 4'd4, CMD_WRITE));
    send_item(OP_COMMAND_WR, bus_word(3'd0, 4'd5, CMD_NOP));
    send_item(OP_COMMAND_WR, bus_word(3'd3, 4'd6, CMD_SPARE_5));
    // Bad unit: the seek lands on the drive picked by the previous write.
    send_item(OP_COMMAND_WR, bus_word(3'd7, 4'd12, CMD_SEEK));
    send_item(OP_STATUS_RD, '0);
    // All started drives finish on this one tick.
    send_item(OP_TICK, '0);
    send_item(OP_STATUS_RD, '0);
    send_item(OP_CONTROL_WR, bus_word(3'd3, 4'd0, CMD_SPARE_1));
    // A busy drive takes the new code but keeps counting.
    send_item(OP_COMMAND_WR, bus_word(3'd0, 4'd1, CMD_SEEK));
    send_item(OP_COMMAND_WR, bus_word(3'd0, 4'd0, CMD_SPARE_7));
    send_item(OP_TICK, '0);
    send_item(OP_STATUS_RD, '0);
    send_item(OP_COMMAND_WR, bus_word(3'd0, 4'd8, CMD_READ));
    send_item(OP_COMMAND_WR, bus_word(3'd0, 4'd0, CMD_WRITE));
    send_item(OP_TICK, '0);
    send_item(OP_STATUS_RD, '0);
  endtask

  task automatic send_random_item();
    int pick;
    logic [OP_W-1:0] op;
    logic [LVL_W-1:0] lvl;
    logic [UNIT_W-1:0] unit;
    logic [CMD_W-1:0] code;
    pick = $urandom_range(99);
    lvl = ($urandom_range(99) < 85) ? LVL_W'($urandom_range(1, 7)) : '0;
    unit = ($urandom_range(99) < 75) ? UNIT_W'($urandom_range(DRIVES))
                                     : UNIT_W'($urandom_range(DRIVES + 1, 15));
    if ($urandom_range(99) < 80) begin
      case ($urandom_range(4))
        0: code = CMD_RECAL;
        1: code = CMD_SEEK;
        2: code = CMD_READ;
        3: code = CMD_WRITE;
        default: code = CMD_NOP;
      endcase
    end else begin
      code = CMD_W'($urandom_range(7));
    end
    if (pick < 25) op = OP_STATUS_RD;
    else if (pick < 37) op = OP_CONTROL_WR;
    else if (pick < 60) op = OP_COMMAND_WR;
    else if (pick < 90) op = OP_TICK;
    else if (pick < 95) op = OP_DATA_RD;
    else op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    send_item(op, bus_word(lvl, unit, code));
  endtask

  task automatic test_random_traffic(input int phase);
    logic [DELAY_W-1:0] delay;
    logic [MASK_W-1:0] online;
    logic [MASK_W-1:0] protect;
    delay = (phase == 0) ? DELAY_W'(1) : DELAY_W'($urandom_range(1, 12));
    online = (phase == 1) ? 8'h00 : (phase == 2) ? 8'hFF : MASK_W'($urandom);
    protect = (phase == 1) ? 8'hFF : (phase == 2) ? 8'h00 : MASK_W'($urandom);
    set_registers(delay, online, protect);
    for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
      send_random_item();
      if ($urandom_range(99) == 0) drain_results();
    end
  endtask

  // Full-scale countdown: nothing finishes until the last of 1023 ticks.
  task automatic test_longest_delay();
    set_registers(10'd1023, 8'hFF, 8'h80);
    send_item(OP_CONTROL_WR, bus_word(3'd4, 4'd0, CMD_NOP));
    send_item(OP_COMMAND_WR, bus_word(3'd0, 4'd8, CMD_SEEK));
    send_item(OP_COMMAND_WR, bus_word(3'd0, 4'd2, CMD_READ));
    for (int n = 0; n < 1022; n++) send_item(OP_TICK, bus_word(3'd0, 4'd0, CMD_NOP));
    send_item(OP_STATUS_RD, '0);
    send_item(OP_TICK, '0);
    send_item(OP_STATUS_RD, '0);
    send_item(OP_CONTROL_WR, bus_word(3'd0, 4'd8, CMD_NOP));
    send_item(OP_STATUS_RD, '0);
  endtask

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    status_result_t want;
    status_result_t seen;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      seen = {out_ch.read_data, out_ch.interrupt_request, out_ch.interrupt_level,
              out_ch.bad_unit};
      if (expected_status.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: result with nothing expected: data=%o irq=%b lvl=%0d bad=%b",
                   seen.read_data, seen.interrupt_request, seen.interrupt_level,
                   seen.bad_unit);
      end else begin
        want = expected_status.pop_front();
        results_checked++;
        if (seen !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("ERROR: result %0d: data %o/%o irq %b/%b lvl %0d/%0d bad %b/%b (exp/got)",
                     results_checked, want.read_data, seen.read_data,
                     want.interrupt_request, seen.interrupt_request,
                     want.interrupt_level, seen.interrupt_level,
                     want.bad_unit, seen.bad_unit);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, expected_status.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.operation <= OP_STATUS_RD;
    in_ch.write_data <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= CFG_DELAY;
    cfg_ch.data <= '0;
    cfg_delay = DELAY_RESET;
    online_mask = '0;
    protect_mask = '0;
    sel_drive = '0;
    prio_chan = '0;
    attn = '0;
    done_f = 1'b0;
    ctrl_busy = 1'b0;
    seek_inc = 1'b0;
    irq_line = 1'b0;
    for (int i = 0; i < MAX_DRIVES; i++) begin
      pend_cmd[i] = CMD_NOP;
      drv_countdown[i] = '0;
    end
    items_sent = 0;
    results_checked = 0;
    mismatch_count = 0;
    completions = 0;
    bad_units = 0;
    settings_used = 1;
    cycle_count = 0;
    send_idle_pct = 24;
    recv_idle_pct = 72;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_control_and_units();
    test_command_codes();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      if (p == 2) begin
        send_idle_pct = 72;
        recv_idle_pct = 24;
      end else if (p == 4) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      test_random_traffic(p);
    end
    test_longest_delay();

    drain_results();
    repeat (4) @(posedge clk);
    $display("Sent %0d bus items under %0d register settings and three idle patterns.",
             items_sent, settings_used);
    $display("Checked %0d results: %0d drive completions, %0d bad unit fields, %0d mismatches.",
             results_checked, completions, bad_units, mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[disk_controller_status_and_command_unit.f]
rtl/dcsc_pkg.sv
rtl/dcsc_if.sv
rtl/dcsc_cfg.sv
rtl/dcsc_in_reg.sv
rtl/dcsc_core.sv
rtl/disk_controller_status_and_command_unit.sv
tb/sv/testbench.sv
